@@ rtl/srq_pkg.sv @@
// Shared types and codes for the string record quicksort block.
// No dependencies; every other file depends on this package.
package srq_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SORT   = 2'd1,
      CMD_READ   = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_FIRST_RECORD = 2'd0,
      REG_LAST_RECORD  = 2'd1
   } reg_index_type;

   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = 5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_OUTER,
      ST_PART_LOOP,
      ST_CMP_A,
      ST_CMP_B,
      ST_CMP_E,
      ST_SWP_A,
      ST_SWP_B,
      ST_SWP_C,
      ST_SWP_D,
      ST_SPLIT,
      ST_DONE
   } state_type;

endpackage

@@ rtl/srq_if.sv @@
// Channel interfaces of the string record quicksort block: command, result, register write.
// Depends on srq_pkg for the command and register index types.
interface srq_req_if;
   logic             valid;
   logic             ready;
   srq_pkg::cmd_type cmd;
   logic [7:0]       record_index;
   logic [5:0]       byte_index;
   logic [7:0]       byte_value;
   modport source (output valid, cmd, record_index, byte_index, byte_value, input ready);
   modport sink   (input valid, cmd, record_index, byte_index, byte_value, output ready);
endinterface

interface srq_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       sort_finished;
   modport source (output valid, data_byte, sort_finished, input ready);
   modport sink   (input valid, data_byte, sort_finished, output ready);
endinterface

interface srq_csr_if;
   logic                   valid;
   logic                   ready;
   srq_pkg::reg_index_type index;
   logic [8:0]             data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/string_record_quicksort_top.sv @@
// Top level of the string record quicksort block.
// Depends on srq_pkg and the channel interfaces in srq_if.sv.
//
// The block keeps MAX_RECORDS text records of LINE_BYTES bytes in one
// synchronous byte memory and executes one command per transaction: load a
// byte, read a byte, or quicksort the records first_record..last_record in
// strcmp order (unsigned bytes, stopping at a zero byte or the record end).
// Every command returns exactly one result. A load or an unused command
// answers from idle, a read from the read state, as the memory read is
// registered. A sort holds the block until it finishes: each record compare
// steps the scan, then per byte examined reads the scanned byte and the pivot
// byte through the single read port before the decision; each record swap
// moves LINE_BYTES bytes one by one. Partitioning is Lomuto with the first
// record as pivot; the larger part goes onto a 16-entry range stack, so a
// sort of n records spends on average on the order of n*log2(n) compares.
// The memory needs no clearing pass: never-written bytes must not be read or
// compared. Register writes are always accepted and must only arrive while
// the block is idle.
module string_record_quicksort_top #(
   parameter int MAX_RECORDS = 256,
   parameter int LINE_BYTES  = 64
) (
   input logic       clock,
   input logic       reset,
   srq_req_if.sink   req_chan,
   srq_rsp_if.source rsp_chan,
   srq_csr_if.sink   csr_chan
);
   import srq_pkg::*;

   localparam int RW    = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int BW    = $clog2(LINE_BYTES);
   localparam int AW    = RW + BW;
   localparam int IW    = ((RW > 9) ? RW : 9) + 2;
   localparam int DEPTH = 2 ** AW;
   localparam logic [BW-1:0]        LAST_BYTE = BW'(LINE_BYTES - 1);
   localparam logic signed [IW-1:0] MAX_IDX   = IW'(MAX_RECORDS - 1);
   localparam logic signed [IW-1:0] ONE       = IW'(1);

   // Record memory: one write and one registered read per cycle.
   logic [7:0]    mem [DEPTH];
   logic [7:0]    rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Range stack: written at the stack pointer, read just below it.
   logic signed [IW-1:0] stk_lo [STACK_DEPTH];
   logic signed [IW-1:0] stk_hi [STACK_DEPTH];
   logic                 stk_we;
   logic signed [IW-1:0] stk_wlo;
   logic signed [IW-1:0] stk_whi;

   state_type            state_ff, state_in;
   logic [SP_W-1:0]      sp_ff, sp_in;
   logic signed [IW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [IW-1:0] store_ff, store_in, scan_ff, scan_in;
   logic signed [IW-1:0] swx_ff, swx_in, swy_ff, swy_in;
   logic [BW-1:0]        k_ff, k_in;
   logic [7:0]           byte_a_ff, byte_a_in;
   logic                 swap_final_ff, swap_final_in;
   logic                 read_ok_ff, read_ok_in;
   logic [7:0]           first_ff;
   logic signed [8:0]    last_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic                 rsp_fin_ff, rsp_fin_in;

   function automatic logic [AW-1:0] rec_addr(logic signed [IW-1:0] r, logic [BW-1:0] k);
      return {r[RW-1:0], k};
   endfunction

   // Command address decode; widen before comparing so any parameter value works.
   logic            slot_free;
   logic            req_fire;
   logic            addr_ok;
   logic [AW-1:0]   req_addr;
   logic [RW+8-1:0] ri_wide;
   logic [BW+6-1:0] bi_wide;
   logic signed [IW-1:0] sort_lo, sort_hi;
   logic signed [IW-1:0] next_store;
   logic                 left_larger;
   logic [SP_W-1:0]      sp_dec;

   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign ri_wide        = (RW + 8)'(req_chan.record_index);
   assign bi_wide        = (BW + 6)'(req_chan.byte_index);
   assign addr_ok        = (ri_wide < (RW + 8)'(MAX_RECORDS))
                        && (bi_wide < (BW + 6)'(LINE_BYTES));
   assign req_addr       = {ri_wide[RW-1:0], bi_wide[BW-1:0]};

   // Clamp the end of the range to the last stored record.
   assign sort_lo     = IW'(first_ff);
   assign sort_hi     = (IW'(last_ff) > MAX_IDX) ? MAX_IDX : IW'(last_ff);
   assign next_store  = store_ff + ONE;
   assign left_larger = (store_ff - lo_ff) > (hi_ff - store_ff);
   assign sp_dec      = sp_ff - SP_W'(1);

   // Registers are always writable; unknown indexes drop.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 8'd0;
         last_ff  <= -9'sd1;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_FIRST_RECORD: first_ff <= csr_chan.data[7:0];
            REG_LAST_RECORD:  last_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_lo[sp_ff[3:0]] <= stk_wlo;
         stk_hi[sp_ff[3:0]] <= stk_whi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      store_ff      <= store_in;
      scan_ff       <= scan_in;
      swx_ff        <= swx_in;
      swy_ff        <= swy_in;
      k_ff          <= k_in;
      byte_a_ff     <= byte_a_in;
      swap_final_ff <= swap_final_in;
      read_ok_ff    <= read_ok_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      store_in      = store_ff;
      scan_in       = scan_ff;
      swx_in        = swx_ff;
      swy_in        = swy_ff;
      k_in          = k_ff;
      byte_a_in     = byte_a_ff;
      swap_final_in = swap_final_ff;
      read_ok_in    = read_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_fin_in    = rsp_fin_ff;
      mem_we        = 1'b0;
      mem_waddr     = req_addr;
      mem_wdata     = req_chan.byte_value;
      mem_raddr     = req_addr;
      stk_we        = 1'b0;
      stk_wlo       = lo_ff;
      stk_whi       = store_ff - ONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.cmd)
                  CMD_LOAD: begin
                     mem_we       = addr_ok;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = 8'd0;
                     rsp_fin_in   = 1'b0;
                  end
                  CMD_SORT: begin
                     lo_in = sort_lo;
                     hi_in = sort_hi;
                     sp_in = '0;
                     state_in = (sort_lo <= MAX_IDX) ? ST_OUTER : ST_DONE;
                  end
                  CMD_READ: begin
                     read_ok_in = addr_ok;
                     state_in   = ST_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = 8'd0;
                     rsp_fin_in   = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = read_ok_ff ? rdata_ff : 8'd0;
            rsp_fin_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_OUTER: begin
            if (hi_ff > lo_ff) begin
               store_in = lo_ff;
               scan_in  = lo_ff + ONE;
               state_in = ST_PART_LOOP;
            end else if (sp_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               sp_in = sp_dec;
               lo_in = stk_lo[sp_dec[3:0]];
               hi_in = stk_hi[sp_dec[3:0]];
            end
         end
         ST_PART_LOOP: begin
            k_in = '0;
            if (scan_ff <= hi_ff) begin
               state_in = ST_CMP_A;
            end else begin
               // Move the pivot into its final slot.
               swx_in        = lo_ff;
               swy_in        = store_ff;
               swap_final_in = 1'b1;
               state_in      = ST_SWP_A;
            end
         end
         ST_CMP_A: begin
            mem_raddr = rec_addr(scan_ff, k_ff);
            state_in  = ST_CMP_B;
         end
         ST_CMP_B: begin
            byte_a_in = rdata_ff;
            mem_raddr = rec_addr(lo_ff, k_ff);
            state_in  = ST_CMP_E;
         end
         ST_CMP_E: begin
            if (byte_a_ff != rdata_ff) begin
               if (byte_a_ff < rdata_ff) begin
                  store_in = next_store;
                  if (next_store != scan_ff) begin
                     swx_in        = next_store;
                     swy_in        = scan_ff;
                     swap_final_in = 1'b0;
                     k_in          = '0;
                     state_in      = ST_SWP_A;
                  end else begin
                     scan_in  = scan_ff + ONE;
                     state_in = ST_PART_LOOP;
                  end
               end else begin
                  scan_in  = scan_ff + ONE;
                  state_in = ST_PART_LOOP;
               end
            end else if (byte_a_ff == 8'd0 || k_ff == LAST_BYTE) begin
               scan_in  = scan_ff + ONE;
               state_in = ST_PART_LOOP;
            end else begin
               k_in     = k_ff + BW'(1);
               state_in = ST_CMP_A;
            end
         end
         ST_SWP_A: begin
            mem_raddr = rec_addr(swx_ff, k_ff);
            state_in  = ST_SWP_B;
         end
         ST_SWP_B: begin
            byte_a_in = rdata_ff;
            mem_raddr = rec_addr(swy_ff, k_ff);
            state_in  = ST_SWP_C;
         end
         ST_SWP_C: begin
            mem_we    = 1'b1;
            mem_waddr = rec_addr(swx_ff, k_ff);
            mem_wdata = rdata_ff;
            state_in  = ST_SWP_D;
         end
         ST_SWP_D: begin
            mem_we    = 1'b1;
            mem_waddr = rec_addr(swy_ff, k_ff);
            mem_wdata = byte_a_ff;
            k_in      = k_ff + BW'(1);
            if (k_ff != LAST_BYTE) begin
               state_in = ST_SWP_A;
            end else if (swap_final_ff) begin
               state_in = ST_SPLIT;
            end else begin
               scan_in  = scan_ff + ONE;
               state_in = ST_PART_LOOP;
            end
         end
         ST_SPLIT: begin
            // Push the larger part while the stack has room, continue with the smaller one.
            if (left_larger) begin
               stk_wlo = lo_ff;
               stk_whi = store_ff - ONE;
               lo_in   = store_ff + ONE;
            end else begin
               stk_wlo = store_ff + ONE;
               stk_whi = hi_ff;
               hi_in   = store_ff - ONE;
            end
            if (sp_ff < SP_W'(STACK_DEPTH)) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + SP_W'(1);
            end
            state_in = ST_OUTER;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = 8'd0;
            rsp_fin_in   = 1'b1;
            sp_in        = '0;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.data_byte     = rsp_data_ff;
   assign rsp_chan.sort_finished = rsp_fin_ff;

`ifndef NO_ASSERTIONS
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("range stack pointer past depth");
   a_idle_stack_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> sp_ff == '0)
      else $error("stack not empty while idle");
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> rsp_valid_ff && !rsp_fin_ff)
      else $error("read command produced no result");
   a_done_answers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid_ff && rsp_fin_ff)
      else $error("sort command produced no finished result");
`endif

endmodule

@@ bench/string_record_quicksort_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for string_record_quicksort_top: byte loads, reads and record sorts.
// Depends on srq_pkg, the channel interfaces in srq_if.sv and the top level RTL.
module string_record_quicksort_top_tb;
   import srq_pkg::*;

   localparam int NREC  = 256;
   localparam int NBYTE = 64;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       sort_finished;
   } answer_type;

   logic clock;
   logic reset;

   srq_req_if req ();
   srq_rsp_if rsp ();
   srq_csr_if csr ();

   string_record_quicksort_top #(.MAX_RECORDS(NREC), .LINE_BYTES(NBYTE)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   // Shadow copy of the record memory and the two range registers.
   logic [7:0]  shadow_store [NREC][NBYTE];
   logic [7:0]  first_rec;
   logic [8:0]  last_rec;

   answer_type  answer_q [$];
   int          fail_count;
   int          sent_count;
   int          send_idle_pct;
   int          rsp_stall_pct;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Drive every input known from time zero, then pulse reset once.
   initial begin
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.cmd          = CMD_UNUSED;
      req.record_index = '0;
      req.byte_index   = '0;
      req.byte_value   = '0;
      rsp.ready        = 1'b0;
      csr.valid        = 1'b0;
      csr.index        = REG_FIRST_RECORD;
      csr.data         = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Safety net: a hung sort or lost result ends the run here.
   initial begin
      #60ms;
      $display("string_record_quicksort_top_tb: FAIL");
      $finish;
   end

   // Result side back-pressure: stall at the phase's rate.
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare every result transaction with the oldest expectation.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (answer_q.size() == 0) begin
            $display("%0t: unexpected result data_byte=%0h sort_finished=%0b",
                     $time, rsp.data_byte, rsp.sort_finished);
            fail_count++;
         end else begin
            want = answer_q.pop_front();
            if (rsp.data_byte !== want.data_byte) begin
               $display("%0t: data_byte expected %0h actual %0h",
                        $time, want.data_byte, rsp.data_byte);
               fail_count++;
            end
            if (rsp.sort_finished !== want.sort_finished) begin
               $display("%0t: sort_finished expected %0b actual %0b",
                        $time, want.sort_finished, rsp.sort_finished);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Sort predictor: strcmp order, first-record pivot, Lomuto split,
   // larger part pushed onto a bounded range stack.
   // ---------------------------------------------------------------
   function automatic int record_order(int a, int b);
      for (int k = 0; k < NBYTE; k++) begin
         if (shadow_store[a][k] != shadow_store[b][k])
            return (shadow_store[a][k] < shadow_store[b][k]) ? -1 : 1;
         if (shadow_store[a][k] == 8'd0)
            return 0;
      end
      return 0;
   endfunction

   function automatic void exchange_records(int a, int b);
      logic [7:0] hold;
      for (int k = 0; k < NBYTE; k++) begin
         hold               = shadow_store[a][k];
         shadow_store[a][k] = shadow_store[b][k];
         shadow_store[b][k] = hold;
      end
   endfunction

   function automatic int split_range(int lo, int hi);
      int boundary;
      boundary = lo;
      for (int scan = lo + 1; scan <= hi; scan++) begin
         if (record_order(scan, lo) < 0) begin
            boundary++;
            if (boundary != scan) exchange_records(boundary, scan);
         end
      end
      exchange_records(lo, boundary);
      return boundary;
   endfunction

   function automatic void sort_records(int lo, int hi);
      int pend_lo [STACK_DEPTH];
      int pend_hi [STACK_DEPTH];
      int depth;
      int p;
      bit left_big;
      depth = 0;
      forever begin
         while (hi > lo) begin
            p        = split_range(lo, hi);
            left_big = ((p - 1) - lo) > (hi - (p + 1));
            if (depth < STACK_DEPTH) begin
               pend_lo[depth] = left_big ? lo : p + 1;
               pend_hi[depth] = left_big ? p - 1 : hi;
               depth++;
            end
            if (left_big) lo = p + 1;
            else hi = p - 1;
         end
         if (depth == 0) return;
         depth--;
         lo = pend_lo[depth];
         hi = pend_hi[depth];
      end
   endfunction

   // Expected result of one accepted command; updates the shadow state.
   function automatic answer_type predict_answer(cmd_type cmd, logic [7:0] ri,
                                                 logic [5:0] bi, logic [7:0] bv);
      answer_type ans;
      int lo;
      int hi;
      ans = '0;
      case (cmd)
         CMD_LOAD: begin
            shadow_store[ri][bi] = bv;
         end
         CMD_SORT: begin
            lo = first_rec;
            hi = $signed(last_rec);
            if (hi > NREC - 1) hi = NREC - 1;
            if (lo <= NREC - 1 && hi > lo) sort_records(lo, hi);
            ans.sort_finished = 1'b1;
         end
         CMD_READ: ans.data_byte = shadow_store[ri][bi];
         default: ;
      endcase
      return ans;
   endfunction

   // ---------------------------------------------------------------
   // Shared drivers
   // ---------------------------------------------------------------
   // Send one command; valid stays high after acceptance until the next
   // gap or the end of the phase drops it.
   task automatic send_command(cmd_type cmd, logic [7:0] ri, logic [5:0] bi,
                               logic [7:0] bv);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.cmd          <= cmd;
      req.record_index <= ri;
      req.byte_index   <= bi;
      req.byte_value   <= bv;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      answer_q.push_back(predict_answer(cmd, ri, bi, bv));
      sent_count++;
   endtask

   // Drop valid and wait until every result is back, plus a little slack.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (answer_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(reg_index_type idx, logic [8:0] value);
      drain();
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      if (idx == REG_FIRST_RECORD) first_rec = value[7:0];
      else last_rec = value;
   endtask

   task automatic set_range(int lo, int hi);
      write_register(REG_FIRST_RECORD, lo[8:0]);
      write_register(REG_LAST_RECORD, hi[8:0]);
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 57; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 57; end
         default: begin send_idle_pct = 25; rsp_stall_pct = 25; end
      endcase
   endtask

   // Small alphabet so records share prefixes and tie often.
   function automatic logic [7:0] text_byte();
      case ($urandom_range(4))
         0: return 8'h61;
         1: return 8'h62;
         2: return 8'h63;
         default: return 8'($urandom_range(255, 1));
      endcase
   endfunction

   // Write all bytes of a record: short string, terminator, random tail;
   // sometimes a string filling the whole record with no terminator.
   task automatic fill_record(int r);
      int len;
      len = ($urandom_range(7) == 0) ? NBYTE : $urandom_range(6);
      for (int k = 0; k < NBYTE; k++) begin
         if (k < len) send_command(CMD_LOAD, r[7:0], k[5:0], text_byte());
         else if (k == len) send_command(CMD_LOAD, r[7:0], k[5:0], 8'd0);
         else send_command(CMD_LOAD, r[7:0], k[5:0], 8'($urandom_range(255)));
      end
   endtask

   // Records 0..7 and 250..255 are always fully written, so they may be sorted.
   function automatic int sortable_record();
      return ($urandom_range(3) == 0) ? $urandom_range(255, 250) : $urandom_range(7);
   endfunction

   task automatic read_back(int lo, int hi);
      for (int r = lo; r <= hi; r++)
         for (int k = 0; k < 8; k++) send_command(CMD_READ, r[7:0], k[5:0], 8'h00);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      set_idling(0);
      // sort with reset registers: empty range, still finishes
      send_command(CMD_SORT, 8'd0, 6'd0, 8'd0);
      send_command(CMD_UNUSED, 8'hFF, 6'h3F, 8'hFF);
      send_command(CMD_LOAD, 8'hFF, 6'h3F, 8'hFF);
      send_command(CMD_LOAD, 8'h00, 6'h00, 8'h00);
      send_command(CMD_LOAD, 8'hAA, 6'h2A, 8'h55);
      send_command(CMD_READ, 8'hFF, 6'h3F, 8'h00);
      send_command(CMD_READ, 8'h00, 6'h00, 8'hFF);
      send_command(CMD_READ, 8'hAA, 6'h2A, 8'h00);
      send_command(CMD_UNUSED, 8'h00, 6'h00, 8'h00);
   endtask

   task automatic test_fill();
      set_idling(3);
      for (int r = 0; r < 8; r++) fill_record(r);
      for (int r = 250; r < NREC; r++) fill_record(r);
   endtask

   task automatic test_range_extremes();
      set_idling(2);
      set_range(255, 255);        // single record at the top
      send_command(CMD_SORT, 8'd0, 6'd0, 8'd0);
      set_range(250, 255);        // tail of the store
      send_command(CMD_SORT, 8'd0, 6'd0, 8'd0);
      read_back(250, 255);
      set_range(0, 7);
      send_command(CMD_SORT, 8'd0, 6'd0, 8'd0);
      read_back(0, 7);
      set_range(5, 2);            // last below first: nothing to do
      send_command(CMD_SORT, 8'd0, 6'd0, 8'd0);
      set_range(0, -1);
      send_command(CMD_SORT, 8'd0, 6'd0, 8'd0);
   endtask

   task automatic test_random();
      int round;
      int a;
      int b;
      int r;
      int k;
      int written_q [$];
      round = 0;
      while (sent_count < 1750) begin
         set_idling(round);
         a = sortable_record();
         b = (a < 8) ? $urandom_range(7) : $urandom_range(255, 250);
         if ($urandom_range(5) != 0 && a > b) begin
            r = a; a = b; b = r;
         end
         set_range(a, b);
         // perturb the sortable records, keeping them fully written
         repeat ($urandom_range(24, 4)) begin
            r = sortable_record();
            send_command(CMD_LOAD, r[7:0], 6'($urandom_range(7)),
                         ($urandom_range(3) == 0) ? 8'd0 : text_byte());
         end
         // scattered traffic anywhere in the store
         repeat ($urandom_range(8)) begin
            r = $urandom_range(255);
            k = $urandom_range(63);
            send_command(CMD_LOAD, r[7:0], k[5:0], 8'($urandom_range(255)));
            written_q.push_back(r * NBYTE + k);
         end
         if ($urandom_range(3) == 0) send_command(CMD_UNUSED, 8'($urandom_range(255)),
                                                  6'($urandom_range(63)),
                                                  8'($urandom_range(255)));
         send_command(CMD_SORT, 8'($urandom_range(255)), 6'($urandom_range(63)),
                      8'($urandom_range(255)));
         repeat ($urandom_range(12, 4)) begin
            if (written_q.size() != 0 && $urandom_range(2) == 0) begin
               k = written_q[$urandom_range(written_q.size() - 1)];
               send_command(CMD_READ, 8'(k / NBYTE), 6'(k % NBYTE), 8'h00);
            end else begin
               r = sortable_record();
               send_command(CMD_READ, r[7:0], 6'($urandom_range(63)),
                            8'($urandom_range(255)));
            end
         end
         round++;
      end
   endtask

   initial begin
      fail_count    = 0;
      sent_count    = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      first_rec     = 8'd0;
      last_rec      = 9'h1FF;
      @(negedge reset);
      @(posedge clock);
      test_directed();
      test_fill();
      test_range_extremes();
      test_random();
      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && answer_q.size() == 0)
         $display("string_record_quicksort_top_tb: PASS");
      else
         $display("string_record_quicksort_top_tb: FAIL");
      $finish;
   end

endmodule
